[hw/rtl/rpm_pkg.sv]
// shared types, constants and codes of the realtime pacing monitor
`timescale 1ns / 1ps

package rpm_pkg;

  localparam int NUM_LEVELS       = 5;
  localparam int LEVEL_BITS       = 3;
  localparam int STEP_BITS        = 20;
  localparam int ADV_BITS         = 40;
  localparam int FRAC_BITS        = 17;
  localparam int FRAC_SHIFT       = 16;
  localparam int OUT_BITS         = 32;
  localparam int CMD_BITS         = 2;
  localparam int IN_TIME_BITS     = 40;
  localparam int CFG_IDX_BITS     = 3;
  localparam int CFG_DATA_BITS    = 40;
  localparam int DEF_COUNT_BITS   = 32;
  localparam int DEF_TIME_BITS    = 40;

  localparam logic [FRAC_BITS-1:0] Q16_ONE = 17'h10000;

  // throttle levels
  localparam logic [LEVEL_BITS-1:0] LVL_ALL_ON     = 3'd0;
  localparam logic [LEVEL_BITS-1:0] LVL_NO_LEARN   = 3'd1;
  localparam logic [LEVEL_BITS-1:0] LVL_NO_SPIKES  = 3'd2;
  localparam logic [LEVEL_BITS-1:0] LVL_MINIMAL    = 3'd3;
  localparam logic [LEVEL_BITS-1:0] LVL_TOO_FAST   = 3'd4;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_STEP = 2'd0,
    CMD_POLL = 2'd1,
    CMD_FOLD = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STEP_SIZE      = 3'd0,
    REG_MAX_ADVANCE    = 3'd1,
    REG_FIRST_SECTION  = 3'd2,
    REG_SECOND_SECTION = 3'd3,
    REG_THIRD_SECTION  = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_SIM,
    ST_GAP,
    ST_CMP_M,
    ST_MUL_T,
    ST_CMP_T,
    ST_UPD_LVL,
    ST_UPD_TOT,
    ST_RESULT,
    ST_FOLD_TOT,
    ST_FOLD_LVL,
    ST_FOLD_OUT
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [2:0] {
    STAT_NOP,
    STAT_INC_LVL,
    STAT_INC_TOT,
    STAT_FOLD_LVL,
    STAT_FOLD_TOT
  } stat_op_t;

  typedef struct packed {
    stat_op_t                op;
    logic [LEVEL_BITS-1:0]   idx;
  } stats_ctl_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]     cmd;
    logic [IN_TIME_BITS-1:0] real_time;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0]   level;
    logic [OUT_BITS-1:0]     real_time_index;
    logic [OUT_BITS-1:0]     level_count;
    logic [OUT_BITS-1:0]     total_count;
    logic                    last;
  } out_item_t;

endpackage

[hw/rtl/rpm_alu.sv]
// shared add/subtract unit used by the sequencer for divide, multiply and compare
`timescale 1ns / 1ps

module rpm_alu #(
  parameter int W = 64
) (
  input  rpm_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     res,
  output logic             borrow
);

  logic [W:0] full;

  always_comb begin
    unique case (op)
      rpm_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
      rpm_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
    endcase
  end

  assign res    = full[W-1:0];
  assign borrow = full[W];

endmodule

[hw/rtl/rpm_stats.sv]
// local and global level counters with one shared saturating adder
`timescale 1ns / 1ps

module rpm_stats #(
  parameter int COUNT_BITS = rpm_pkg::DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rpm_pkg::stats_ctl_t    ctl,
  output logic [COUNT_BITS-1:0]  sel_local,
  output logic [COUNT_BITS-1:0]  sel_global,
  output logic [COUNT_BITS-1:0]  local_total,
  output logic [COUNT_BITS-1:0]  global_total
);

  logic [COUNT_BITS-1:0] loc_r [rpm_pkg::NUM_LEVELS];
  logic [COUNT_BITS-1:0] glb_r [rpm_pkg::NUM_LEVELS];
  logic [COUNT_BITS-1:0] ltot_r;
  logic [COUNT_BITS-1:0] gtot_r;

  logic [COUNT_BITS-1:0] add_a;
  logic [COUNT_BITS-1:0] add_b;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] sat_sum;

  assign sel_local    = loc_r[ctl.idx];
  assign sel_global   = glb_r[ctl.idx];
  assign local_total  = ltot_r;
  assign global_total = gtot_r;

  always_comb begin
    unique case (ctl.op)
      rpm_pkg::STAT_INC_LVL: begin
        add_a = loc_r[ctl.idx];
        add_b = COUNT_BITS'(1);
      end
      rpm_pkg::STAT_INC_TOT: begin
        add_a = ltot_r;
        add_b = COUNT_BITS'(1);
      end
      rpm_pkg::STAT_FOLD_LVL: begin
        add_a = glb_r[ctl.idx];
        add_b = loc_r[ctl.idx];
      end
      rpm_pkg::STAT_FOLD_TOT: begin
        add_a = gtot_r;
        add_b = ltot_r;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
    sum     = {1'b0, add_a} + {1'b0, add_b};
    sat_sum = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rpm_pkg::NUM_LEVELS; i++) begin
        loc_r[i] <= '0;
        glb_r[i] <= '0;
      end
      ltot_r <= '0;
      gtot_r <= '0;
    end else begin
      unique case (ctl.op)
        rpm_pkg::STAT_INC_LVL: loc_r[ctl.idx] <= sat_sum;
        rpm_pkg::STAT_INC_TOT: ltot_r <= sat_sum;
        rpm_pkg::STAT_FOLD_LVL: begin
          glb_r[ctl.idx] <= sat_sum;
          loc_r[ctl.idx] <= '0;
        end
        rpm_pkg::STAT_FOLD_TOT: begin
          gtot_r <= sat_sum;
          ltot_r <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/realtime_pacing_monitor.sv]
// top level: configuration registers, sequencer and output register of the pacing monitor
// usage:
//   in channel (in_valid/in_ready/in_data) takes a command and the measured real time.
//   step and poll commands give one item: throttle level, real time index, the new
//   local count of that level and the new local total. a fold command gives five
//   items, one per level, with the global counts; last marks the final one.
//   cfg channel writes the five pacing registers; any write restarts the step count.
//   cfg_ready is always high. write configuration only while the block is idle.
// steps:
//   step/poll: restoring division, shift-add multiply for simulated time, one or two
//   compares, up to three threshold passes (17-bit shift-add multiply plus compare)
//   and an update of the counters before the result is emitted.
//   fold: the totals fold first, then each level folds and emits its item; output stalls can hold it.
//   in_ready is low while an item works.
// reset and stall:
//   synchronous reset clears all counters, loads the register defaults and goes idle.
//   a result sits in the output register until taken; the block accepts the next
//   item meanwhile, but stops before loading a new result into an occupied register.
`timescale 1ns / 1ps

module realtime_pacing_monitor #(
  parameter int COUNT_BITS = rpm_pkg::DEF_COUNT_BITS,
  parameter int TIME_BITS  = rpm_pkg::DEF_TIME_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rpm_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rpm_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rpm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rpm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SB   = rpm_pkg::STEP_BITS;
  localparam int FB   = rpm_pkg::FRAC_BITS;
  localparam int OB   = rpm_pkg::OUT_BITS;
  localparam int LB   = rpm_pkg::LEVEL_BITS;
  localparam int AW_A = COUNT_BITS + SB;
  localparam int AW_B = TIME_BITS + FB;
  localparam int AW   = (AW_A > AW_B) ? AW_A : AW_B;
  localparam int CNTW = $clog2(TIME_BITS + 1);
  localparam int CX   = ((COUNT_BITS > OB) ? COUNT_BITS : OB) + 1;
  localparam int QX   = ((TIME_BITS > OB) ? TIME_BITS : OB) + 1;

  // configuration
  logic [SB-1:0]                    step_size_r;
  logic [rpm_pkg::ADV_BITS-1:0]     max_adv_r;
  logic [FB-1:0]                    first_r;
  logic [FB-1:0]                    second_r;
  logic [FB-1:0]                    third_r;
  logic                             cfg_hit;

  // sequencer and datapath
  rpm_pkg::state_t                  state_r, state_nxt;
  logic [COUNT_BITS-1:0]            step_count_r;
  logic [AW-1:0]                    acc_r, acc_nxt;
  logic [AW-1:0]                    mc_r, mc_nxt;
  logic [AW-1:0]                    gap_r, gap_nxt;
  logic [TIME_BITS-1:0]             q_r, q_nxt;
  logic [TIME_BITS-1:0]             real_r, real_nxt;
  logic [CNTW-1:0]                  cnt_r, cnt_nxt;
  logic [OB-1:0]                    idx_r, idx_nxt;
  logic [LB-1:0]                    lvl_r, lvl_nxt;
  logic [1:0]                       k_r, k_nxt;
  logic                             out_valid_r;
  rpm_pkg::out_item_t               out_data_r, out_data_nxt;
  logic                             out_load;
  logic                             out_free;
  logic                             accept;

  // derived pacing values
  logic [SB-1:0]                    step_eff;
  logic [TIME_BITS-1:0]             step_tw;
  logic [TIME_BITS-1:0]             ma_tw;
  logic [TIME_BITS-1:0]             m_tw;
  logic [FB-1:0]                    s1, s2, s3;
  logic [FB-1:0]                    f_tab [3];
  logic [1:0]                       k_inc;

  // shared unit
  rpm_pkg::alu_op_t                 alu_op;
  logic [AW-1:0]                    alu_a, alu_b, alu_res;
  logic                             alu_borrow;

  // division helpers
  logic [SB:0]                      rem_sh;
  logic [TIME_BITS-1:0]             quo;
  logic [QX-1:0]                    quo_x;

  // statistics
  rpm_pkg::stats_ctl_t              st_ctl;
  logic [COUNT_BITS-1:0]            sel_local, sel_global, local_total, global_total;
  logic [CX-1:0]                    cnt_x, tot_x;
  logic [OB-1:0]                    cnt_sat, tot_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == rpm_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign cfg_hit = cfg_valid && (cfg_index == rpm_pkg::REG_STEP_SIZE ||
                                 cfg_index == rpm_pkg::REG_MAX_ADVANCE ||
                                 cfg_index == rpm_pkg::REG_FIRST_SECTION ||
                                 cfg_index == rpm_pkg::REG_SECOND_SECTION ||
                                 cfg_index == rpm_pkg::REG_THIRD_SECTION);

  assign step_eff = (step_size_r == '0) ? SB'(1) : step_size_r;
  assign step_tw  = TIME_BITS'(step_eff);
  assign ma_tw    = TIME_BITS'(max_adv_r);
  assign m_tw     = (ma_tw < step_tw) ? step_tw : ma_tw;

  assign s3 = (third_r > rpm_pkg::Q16_ONE) ? rpm_pkg::Q16_ONE : third_r;
  assign s2 = (second_r > s3) ? s3 : second_r;
  assign s1 = (first_r > s2) ? s2 : first_r;
  assign f_tab[0] = rpm_pkg::Q16_ONE - s1;
  assign f_tab[1] = rpm_pkg::Q16_ONE - s2;
  assign f_tab[2] = rpm_pkg::Q16_ONE - s3;
  assign k_inc    = k_r + 2'd1;

  assign rem_sh = {acc_r[SB-1:0], q_r[TIME_BITS-1]};
  assign quo    = {q_r[TIME_BITS-2:0], ~alu_borrow};
  assign quo_x  = QX'(quo);

  // counts as seen on the 32-bit result fields
  assign cnt_x   = CX'((state_r == rpm_pkg::ST_FOLD_OUT) ? sel_global : sel_local);
  assign tot_x   = CX'((state_r == rpm_pkg::ST_FOLD_OUT) ? global_total : local_total);
  assign cnt_sat = (|cnt_x[CX-1:OB]) ? '1 : cnt_x[OB-1:0];
  assign tot_sat = (|tot_x[CX-1:OB]) ? '1 : tot_x[OB-1:0];

  rpm_alu #(
    .W (AW)
  ) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  rpm_stats #(
    .COUNT_BITS (COUNT_BITS)
  ) u_stats (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (st_ctl),
    .sel_local    (sel_local),
    .sel_global   (sel_global),
    .local_total  (local_total),
    .global_total (global_total)
  );

  always_comb begin
    state_nxt    = state_r;
    acc_nxt      = acc_r;
    mc_nxt       = mc_r;
    gap_nxt      = gap_r;
    q_nxt        = q_r;
    real_nxt     = real_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    lvl_nxt      = lvl_r;
    k_nxt        = k_r;
    alu_op       = rpm_pkg::ALU_ADD;
    alu_a        = acc_r;
    alu_b        = '0;
    st_ctl.op    = rpm_pkg::STAT_NOP;
    st_ctl.idx   = lvl_r;
    out_load     = 1'b0;
    out_data_nxt = out_data_r;

    unique case (state_r)
      rpm_pkg::ST_IDLE: begin
        if (accept) begin
          real_nxt = TIME_BITS'(in_data.real_time);
          unique case (in_data.cmd)
            rpm_pkg::CMD_STEP, rpm_pkg::CMD_POLL: begin
              acc_nxt   = '0;
              q_nxt     = TIME_BITS'(in_data.real_time);
              cnt_nxt   = CNTW'(TIME_BITS);
              state_nxt = rpm_pkg::ST_DIV;
            end
            rpm_pkg::CMD_FOLD: state_nxt = rpm_pkg::ST_FOLD_TOT;
            default: ;
          endcase
        end
      end

      rpm_pkg::ST_DIV: begin
        alu_op = rpm_pkg::ALU_SUB;
        alu_a  = AW'(rem_sh);
        alu_b  = AW'(step_eff);
        if (cnt_r == CNTW'(1)) begin
          idx_nxt   = (|quo_x[QX-1:OB]) ? '1 : quo_x[OB-1:0];
          acc_nxt   = '0;
          mc_nxt    = AW'(step_count_r);
          q_nxt     = TIME_BITS'(step_eff);
          cnt_nxt   = CNTW'(SB);
          state_nxt = rpm_pkg::ST_MUL_SIM;
        end else begin
          acc_nxt = alu_borrow ? AW'(rem_sh) : alu_res;
          q_nxt   = quo;
          cnt_nxt = cnt_r - CNTW'(1);
        end
      end

      rpm_pkg::ST_MUL_SIM, rpm_pkg::ST_MUL_T: begin
        alu_op  = rpm_pkg::ALU_ADD;
        alu_a   = acc_r;
        alu_b   = q_r[0] ? mc_r : '0;
        acc_nxt = alu_res;
        mc_nxt  = mc_r << 1;
        q_nxt   = q_r >> 1;
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          state_nxt = (state_r == rpm_pkg::ST_MUL_SIM) ? rpm_pkg::ST_GAP : rpm_pkg::ST_CMP_T;
        end
      end

      rpm_pkg::ST_GAP: begin
        alu_op = rpm_pkg::ALU_SUB;
        alu_a  = acc_r;
        alu_b  = AW'(real_r);
        if (alu_borrow) begin
          lvl_nxt   = rpm_pkg::LVL_MINIMAL;
          state_nxt = rpm_pkg::ST_UPD_LVL;
        end else begin
          gap_nxt   = alu_res;
          state_nxt = rpm_pkg::ST_CMP_M;
        end
      end

      rpm_pkg::ST_CMP_M: begin
        alu_op = rpm_pkg::ALU_SUB;
        alu_a  = gap_r;
        alu_b  = AW'(m_tw);
        if (!alu_borrow) begin
          lvl_nxt   = rpm_pkg::LVL_TOO_FAST;
          state_nxt = rpm_pkg::ST_UPD_LVL;
        end else begin
          k_nxt     = 2'd0;
          acc_nxt   = '0;
          mc_nxt    = AW'(m_tw);
          q_nxt     = TIME_BITS'(f_tab[0]);
          cnt_nxt   = CNTW'(FB);
          state_nxt = rpm_pkg::ST_MUL_T;
        end
      end

      rpm_pkg::ST_CMP_T: begin
        // threshold below gap when floor(m*f/2^16) - gap borrows
        alu_op = rpm_pkg::ALU_SUB;
        alu_a  = acc_r >> rpm_pkg::FRAC_SHIFT;
        alu_b  = gap_r;
        if (alu_borrow) begin
          lvl_nxt   = LB'(k_r);
          state_nxt = rpm_pkg::ST_UPD_LVL;
        end else if (k_r == 2'd2) begin
          lvl_nxt   = rpm_pkg::LVL_MINIMAL;
          state_nxt = rpm_pkg::ST_UPD_LVL;
        end else begin
          k_nxt     = k_inc;
          acc_nxt   = '0;
          mc_nxt    = AW'(m_tw);
          q_nxt     = TIME_BITS'(f_tab[k_inc]);
          cnt_nxt   = CNTW'(FB);
          state_nxt = rpm_pkg::ST_MUL_T;
        end
      end

      rpm_pkg::ST_UPD_LVL: begin
        st_ctl.op = rpm_pkg::STAT_INC_LVL;
        state_nxt = rpm_pkg::ST_UPD_TOT;
      end

      rpm_pkg::ST_UPD_TOT: begin
        st_ctl.op = rpm_pkg::STAT_INC_TOT;
        state_nxt = rpm_pkg::ST_RESULT;
      end

      rpm_pkg::ST_RESULT: begin
        if (out_free) begin
          out_load                     = 1'b1;
          out_data_nxt.level           = lvl_r;
          out_data_nxt.real_time_index = idx_r;
          out_data_nxt.level_count     = cnt_sat;
          out_data_nxt.total_count     = tot_sat;
          out_data_nxt.last            = 1'b1;
          state_nxt                    = rpm_pkg::ST_IDLE;
        end
      end

      rpm_pkg::ST_FOLD_TOT: begin
        st_ctl.op = rpm_pkg::STAT_FOLD_TOT;
        lvl_nxt   = rpm_pkg::LVL_ALL_ON;
        state_nxt = rpm_pkg::ST_FOLD_LVL;
      end

      rpm_pkg::ST_FOLD_LVL: begin
        st_ctl.op = rpm_pkg::STAT_FOLD_LVL;
        state_nxt = rpm_pkg::ST_FOLD_OUT;
      end

      rpm_pkg::ST_FOLD_OUT: begin
        if (out_free) begin
          out_load                     = 1'b1;
          out_data_nxt.level           = lvl_r;
          out_data_nxt.real_time_index = '0;
          out_data_nxt.level_count     = cnt_sat;
          out_data_nxt.total_count     = tot_sat;
          out_data_nxt.last            = (lvl_r == LB'(rpm_pkg::NUM_LEVELS - 1));
          if (lvl_r == LB'(rpm_pkg::NUM_LEVELS - 1)) begin
            state_nxt = rpm_pkg::ST_IDLE;
          end else begin
            lvl_nxt   = lvl_r + LB'(1);
            state_nxt = rpm_pkg::ST_FOLD_LVL;
          end
        end
      end

      default: state_nxt = rpm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rpm_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      step_count_r <= '0;
      step_size_r  <= SB'(1);
      max_adv_r    <= '0;
      first_r      <= rpm_pkg::Q16_ONE;
      second_r     <= rpm_pkg::Q16_ONE;
      third_r      <= rpm_pkg::Q16_ONE;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_hit) begin
        step_count_r <= '0;
      end else if (accept && in_data.cmd == rpm_pkg::CMD_STEP && step_count_r != '1) begin
        step_count_r <= step_count_r + COUNT_BITS'(1);
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          rpm_pkg::REG_STEP_SIZE:      step_size_r <= cfg_data[SB-1:0];
          rpm_pkg::REG_MAX_ADVANCE:    max_adv_r   <= cfg_data[rpm_pkg::ADV_BITS-1:0];
          rpm_pkg::REG_FIRST_SECTION:  first_r     <= cfg_data[FB-1:0];
          rpm_pkg::REG_SECOND_SECTION: second_r    <= cfg_data[FB-1:0];
          rpm_pkg::REG_THIRD_SECTION:  third_r     <= cfg_data[FB-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    mc_r       <= mc_nxt;
    gap_r      <= gap_nxt;
    q_r        <= q_nxt;
    real_r     <= real_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    lvl_r      <= lvl_nxt;
    k_r        <= k_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
